// ===== rtl/core/btt_pkg.sv =====
// Shared types and constants of the block text tokenizer.
package btt_pkg;

  localparam int unsigned NAME_CHARS_DEF = 7;
  localparam int unsigned MAX_DEPTH_DEF  = 255;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_CLOSE = 8'h7D;

  // Known block names
  localparam int unsigned PLANE_LEN   = 5;
  localparam int unsigned POINT3D_LEN = 7;
  localparam int unsigned CUBE_LEN    = 4;
  localparam logic [7:0] PLANE_STR   [PLANE_LEN]   = '{8'h50, 8'h6C, 8'h61, 8'h6E, 8'h65};
  localparam logic [7:0] POINT3D_STR [POINT3D_LEN] =
    '{8'h50, 8'h6F, 8'h69, 8'h6E, 8'h74, 8'h33, 8'h64};
  localparam logic [7:0] CUBE_STR    [CUBE_LEN]    = '{8'h43, 8'h75, 8'h62, 8'h65};

  typedef enum logic [2:0] {
    KIND_BODY  = 3'd0,
    KIND_OPEN  = 3'd1,
    KIND_CLOSE = 3'd2,
    KIND_ERROR = 3'd3,
    KIND_END   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    BLK_PLANE   = 2'd0,
    BLK_POINT3D = 2'd1,
    BLK_CUBE    = 2'd2
  } blk_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_BAD_NAME   = 3'd1,
    ERR_STRAY      = 3'd2,
    ERR_UNEXPECTED = 3'd3,
    ERR_TOO_DEEP   = 3'd4
  } err_t;

  typedef enum logic [2:0] {
    PH_NAME = 3'b001,
    PH_BODY = 3'b010,
    PH_HALT = 3'b100
  } phase_t;

  typedef struct packed {
    kind_t      kind;
    blk_t       block_kind;
    logic [7:0] body_byte;
    err_t       error_code;
    logic       final_res;
  } res_t;

  // All results caused by one input byte
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } rec_t;

endpackage

// ===== rtl/core/block_text_tokenizer_core.sv =====
// Block text tokenizer: byte filter, block name check and brace tracking.
// Results are registered: an accepted beat's results enter the result queue and are offered on m_*.
// Throughput: one input beat per cycle while the two-record result queue has room; the final
//   byte of a stream may cause two result beats, and while both leave, the queue can fill and
//   s_tready drops, as it also does when m_tready is held low.
// Reset (rst, synchronous, active high): parser back to name reading, comment off,
//   depth zero, result queue empty. The final byte of a stream clears the parser the same way.
module block_text_tokenizer_core
  import btt_pkg::*;
#(
  parameter int unsigned NameChars = NAME_CHARS_DEF,  // 7..16
  parameter int unsigned MaxDepth  = MAX_DEPTH_DEF    // 1..65535
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic        s_tlast,   // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [1:0] block_kind, [9:2] body_byte, [12:10] error_code
  output logic [2:0]  m_tuser,   // [2:0] kind
  output logic        m_tlast    // final_res
);

  localparam int unsigned LenW   = $clog2(NameChars + 1);
  localparam int unsigned IdxW   = $clog2(NameChars);
  localparam int unsigned DepthW = $clog2(MaxDepth + 1);

  // Parser state
  logic              in_comment, in_comment_next;
  phase_t            phase, phase_next;
  logic [7:0]        name_chars [NameChars];
  logic [LenW-1:0]   name_length, name_length_next;
  logic              name_too_long, name_too_long_next;
  logic [DepthW-1:0] nest_depth, nest_depth_next;

  // Result queue: two records, each one or two result beats
  rec_t       q [2];
  logic       wr_ptr, rd_ptr, sel;
  logic [1:0] cnt;

  logic accept, keep, name_wr, push, pop_beat, pop_rec;
  logic is_plane, is_point3d, is_cube;
  rec_t rec;
  res_t cur;

  assign s_tready = (cnt != 2'd2);
  assign accept   = s_tvalid & s_tready;

  // Name compare against the three known types; bytes past name_length never decide a match
  always_comb begin
    is_plane   = !name_too_long && (name_length == LenW'(PLANE_LEN));
    is_point3d = !name_too_long && (name_length == LenW'(POINT3D_LEN));
    is_cube    = !name_too_long && (name_length == LenW'(CUBE_LEN));
    for (int i = 0; i < PLANE_LEN; i++)
      if (name_chars[i] != PLANE_STR[i]) is_plane = 1'b0;
    for (int i = 0; i < POINT3D_LEN; i++)
      if (name_chars[i] != POINT3D_STR[i]) is_point3d = 1'b0;
    for (int i = 0; i < CUBE_LEN; i++)
      if (name_chars[i] != CUBE_STR[i]) is_cube = 1'b0;
  end

  // Per-byte parse step
  always_comb begin
    res_t r_byte, r_end;
    logic has_byte, has_end;
    r_byte   = '{kind: KIND_BODY, block_kind: BLK_PLANE, body_byte: 8'h00,
                 error_code: ERR_NONE, final_res: 1'b0};
    r_end    = r_byte;
    has_byte = 1'b0;
    has_end  = 1'b0;
    name_wr  = 1'b0;

    in_comment_next    = in_comment;
    phase_next         = phase;
    name_length_next   = name_length;
    name_too_long_next = name_too_long;
    nest_depth_next    = nest_depth;

    keep = 1'b0;
    if (s_tdata == CH_HASH) begin
      in_comment_next = !in_comment;
    end else if (s_tdata != CH_SPACE && s_tdata != CH_LF && s_tdata != CH_NUL &&
                 s_tdata != CH_TAB && !in_comment) begin
      keep = 1'b1;
    end

    if (keep) begin
      case (phase)
        PH_NAME: begin
          if (s_tdata == CH_OPEN) begin
            has_byte = 1'b1;
            if (is_plane || is_point3d || is_cube) begin
              r_byte.kind       = KIND_OPEN;
              r_byte.block_kind = is_plane ? BLK_PLANE : (is_point3d ? BLK_POINT3D : BLK_CUBE);
              phase_next        = PH_BODY;
              nest_depth_next   = '0;
            end else begin
              r_byte.kind       = KIND_ERROR;
              r_byte.error_code = ERR_BAD_NAME;
              phase_next        = PH_HALT;
            end
            name_length_next   = '0;
            name_too_long_next = 1'b0;
          end else if (s_tdata == CH_CLOSE) begin
            has_byte          = 1'b1;
            r_byte.kind       = KIND_ERROR;
            r_byte.error_code = ERR_STRAY;
            phase_next        = PH_HALT;
          end else if (name_length < LenW'(NameChars)) begin
            name_wr          = 1'b1;
            name_length_next = name_length + 1'b1;
          end else begin
            name_too_long_next = 1'b1;
          end
        end
        PH_BODY: begin
          has_byte = 1'b1;
          if (s_tdata == CH_OPEN) begin
            if (nest_depth == DepthW'(MaxDepth)) begin
              r_byte.kind       = KIND_ERROR;
              r_byte.error_code = ERR_TOO_DEEP;
              phase_next        = PH_HALT;
            end else begin
              nest_depth_next  = nest_depth + 1'b1;
              r_byte.body_byte = s_tdata;
            end
          end else if (s_tdata == CH_CLOSE && nest_depth == '0) begin
            r_byte.kind        = KIND_CLOSE;
            phase_next         = PH_NAME;
            name_length_next   = '0;
            name_too_long_next = 1'b0;
          end else begin
            if (s_tdata == CH_CLOSE) nest_depth_next = nest_depth - 1'b1;
            r_byte.body_byte = s_tdata;
          end
        end
        default: ;  // halted: nothing until the final byte
      endcase
    end

    // End of stream
    if (s_tlast) begin
      if (phase != PH_NAME && phase != PH_BODY) begin
        has_end      = 1'b1;
        r_end.kind   = KIND_ERROR;
      end else if (phase_next == PH_BODY ||
                   (phase_next == PH_NAME &&
                    (name_length_next != '0 || name_too_long_next))) begin
        has_end          = 1'b1;
        r_end.kind       = KIND_ERROR;
        r_end.error_code = ERR_UNEXPECTED;
      end else if (phase_next == PH_NAME) begin
        has_end    = 1'b1;
        r_end.kind = KIND_END;
      end
      r_byte.final_res = !has_end;
      r_end.final_res  = 1'b1;
      in_comment_next    = 1'b0;
      phase_next         = PH_NAME;
      name_length_next   = '0;
      name_too_long_next = 1'b0;
      nest_depth_next    = '0;
    end

    rec.two = has_byte & has_end;
    rec.r0  = has_byte ? r_byte : r_end;
    rec.r1  = r_end;
    push    = accept & (has_byte | has_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_comment    <= 1'b0;
      phase         <= PH_NAME;
      name_length   <= '0;
      name_too_long <= 1'b0;
      nest_depth    <= '0;
    end else if (accept) begin
      in_comment    <= in_comment_next;
      phase         <= phase_next;
      name_length   <= name_length_next;
      name_too_long <= name_too_long_next;
      nest_depth    <= nest_depth_next;
    end
  end

  // Name bytes carry no reset; bytes past name_length never decide a match
  always_ff @(posedge clk) begin
    if (accept && name_wr) begin
      name_chars[name_length[IdxW-1:0]] <= s_tdata;
    end
  end

  // Output side
  assign m_tvalid = (cnt != 2'd0);
  assign cur      = sel ? q[rd_ptr].r1 : q[rd_ptr].r0;
  assign pop_beat = m_tvalid & m_tready;
  assign pop_rec  = pop_beat & (sel | !q[rd_ptr].two);

  assign m_tdata  = {3'b000, cur.error_code, cur.body_byte, cur.block_kind};
  assign m_tuser  = cur.kind;
  assign m_tlast  = cur.final_res;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      sel    <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop_rec) begin
        rd_ptr <= !rd_ptr;
        sel    <= 1'b0;
      end else if (pop_beat) begin
        sel <= 1'b1;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop_rec};
    end
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("result queue overfilled");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    nest_depth <= DepthW'(MaxDepth))
    else $error("nest depth above limit");

  a_stall_needs_data: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result pending");

  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> phase == PH_NAME && !in_comment && name_length == '0 &&
                          nest_depth == '0)
    else $error("parser not cleared after final byte");

  a_end_pushes: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |-> push)
    else $error("final byte produced no result");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for block_text_tokenizer_core.
module tb;
  import btt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] ch
  logic        s_tlast = 1'b0; // end_of_text
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [1:0] block_kind, [9:2] body_byte, [12:10] error_code
  logic [2:0]  m_tuser;        // [2:0] kind
  logic        m_tlast;        // final_res

  block_text_tokenizer_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Tokens the block still owes us, oldest first
  res_t        token_q[$];
  int unsigned mismatches = 0;
  int unsigned beats_sent = 0;
  int unsigned cycles = 0;
  logic        tx_quiet = 1'b0;
  logic        rx_quiet = 1'b0;
  int unsigned holdoff_req = 0;
  int unsigned holdoff_left = 0;
  logic [7:0]  text_q[$];

  // Parser shadow state
  logic        cmt_open;
  phase_t      parse_phase;
  logic [7:0]  name_buf[NAME_CHARS_DEF];
  int unsigned name_len;
  logic        name_long;
  int unsigned depth;

  task automatic clear_name();
    foreach (name_buf[i]) name_buf[i] = '0;
    name_len  = 0;
    name_long = 1'b0;
  endtask

  task automatic reset_parser();
    cmt_open    = 1'b0;
    parse_phase = PH_NAME;
    depth       = 0;
    clear_name();
  endtask

  function automatic int unsigned known_len(blk_t b);
    case (b)
      BLK_PLANE:   return PLANE_LEN;
      BLK_POINT3D: return POINT3D_LEN;
      default:     return CUBE_LEN;
    endcase
  endfunction

  function automatic logic [7:0] known_char(blk_t b, int unsigned i);
    case (b)
      BLK_PLANE:   return PLANE_STR[i];
      BLK_POINT3D: return POINT3D_STR[i];
      default:     return CUBE_STR[i];
    endcase
  endfunction

  function automatic logic name_is(blk_t b);
    logic ok;
    ok = !name_long && name_len == known_len(b);
    for (int unsigned i = 0; ok && i < known_len(b); i++)
      ok = name_buf[i] == known_char(b, i);
    return ok;
  endfunction

  function automatic res_t make_token(kind_t k, blk_t b, logic [7:0] by, err_t e);
    res_t r;
    r.kind       = k;
    r.block_kind = b;
    r.body_byte  = by;
    r.error_code = e;
    r.final_res  = 1'b0;
    return r;
  endfunction

  // Works out the tokens caused by one accepted byte and queues them.
  task automatic tokenize_byte(input logic [7:0] c, input logic last);
    res_t out_q[$];
    res_t r;
    logic keep;
    logic was_halted;
    was_halted = parse_phase == PH_HALT;
    keep = 1'b0;
    if (c == CH_HASH)
      cmt_open = !cmt_open;
    else if (c != CH_SPACE && c != CH_LF && c != CH_NUL && c != CH_TAB && !cmt_open)
      keep = 1'b1;

    if (keep && parse_phase == PH_NAME) begin
      if (c == CH_OPEN) begin
        if (name_is(BLK_PLANE) || name_is(BLK_POINT3D) || name_is(BLK_CUBE)) begin
          r = make_token(KIND_OPEN, name_is(BLK_PLANE) ? BLK_PLANE :
                         name_is(BLK_POINT3D) ? BLK_POINT3D : BLK_CUBE, '0, ERR_NONE);
          out_q = {out_q, r};
          parse_phase = PH_BODY;
          depth = 0;
        end else begin
          // block_kind reads as zero on anything but an open
          out_q = {out_q, make_token(KIND_ERROR, BLK_PLANE, '0, ERR_BAD_NAME)};
          parse_phase = PH_HALT;
        end
        clear_name();
      end else if (c == CH_CLOSE) begin
        out_q = {out_q, make_token(KIND_ERROR, BLK_PLANE, '0, ERR_STRAY)};
        parse_phase = PH_HALT;
      end else if (name_len < NAME_CHARS_DEF) begin
        name_buf[name_len] = c;
        name_len++;
      end else begin
        name_long = 1'b1;
      end
    end else if (keep && parse_phase == PH_BODY) begin
      if (c == CH_OPEN) begin
        if (depth >= MAX_DEPTH_DEF) begin
          out_q = {out_q, make_token(KIND_ERROR, BLK_PLANE, '0, ERR_TOO_DEEP)};
          parse_phase = PH_HALT;
        end else begin
          depth++;
          out_q = {out_q, make_token(KIND_BODY, BLK_PLANE, c, ERR_NONE)};
        end
      end else if (c == CH_CLOSE) begin
        if (depth == 0) begin
          out_q = {out_q, make_token(KIND_CLOSE, BLK_PLANE, '0, ERR_NONE)};
          parse_phase = PH_NAME;
          clear_name();
        end else begin
          depth--;
          out_q = {out_q, make_token(KIND_BODY, BLK_PLANE, c, ERR_NONE)};
        end
      end else begin
        out_q = {out_q, make_token(KIND_BODY, BLK_PLANE, c, ERR_NONE)};
      end
    end

    if (last) begin
      if (was_halted)
        out_q = {out_q, make_token(KIND_ERROR, BLK_PLANE, '0, ERR_NONE)};
      else if (parse_phase == PH_BODY ||
               (parse_phase == PH_NAME && (name_len != 0 || name_long)))
        out_q = {out_q, make_token(KIND_ERROR, BLK_PLANE, '0, ERR_UNEXPECTED)};
      else if (parse_phase == PH_NAME)
        out_q = {out_q, make_token(KIND_END, BLK_PLANE, '0, ERR_NONE)};
      if (out_q.size() != 0) begin
        r = out_q.pop_back();
        r.final_res = 1'b1;
        out_q = {out_q, r};
      end
      reset_parser();
    end
    token_q = {token_q, out_q};
  endtask

  // Offer one byte; returns at the edge it is taken, tvalid still high.
  task automatic send_beat(input logic [7:0] c, input logic last);
    if (!tx_quiet && $urandom_range(99) < 30) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    tokenize_byte(c, last);
    beats_sent++;
  endtask

  task automatic send_text(input string s, input logic last_at_end);
    for (int i = 0; i < s.len(); i++)
      send_beat(s[i], last_at_end && i == s.len() - 1);
  endtask

  task automatic send_text_q();
    foreach (text_q[i]) send_beat(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  // Sender stops until the block has delivered everything it owes.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (token_q.size() != 0);
  endtask

  task automatic report_mismatch(input string what, input res_t want, input res_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"mismatch, %s: exp kind %0d blk %0d byte %02h err %0d last %0b",
                " | got kind %0d blk %0d byte %02h err %0d last %0b"},
               what, want.kind, want.block_kind, want.body_byte, want.error_code,
               want.final_res, got.kind, got.block_kind, got.body_byte,
               got.error_code, got.final_res);
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      m_tready     <= 1'b0;
    end else if (holdoff_req != 0) begin
      holdoff_left <= holdoff_req;
      holdoff_req  <= 0;
      m_tready     <= 1'b0;
    end else begin
      m_tready <= rx_quiet || $urandom_range(99) >= 30;
    end
  end

  // Result checker
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.kind       = kind_t'(m_tuser);
      got.block_kind = blk_t'(m_tdata[1:0]);
      got.body_byte  = m_tdata[9:2];
      got.error_code = err_t'(m_tdata[12:10]);
      got.final_res  = m_tlast;
      if (token_q.size() == 0) begin
        report_mismatch("no token pending", got, got);
      end else begin
        want = token_q.pop_front();
        if (got.kind !== want.kind || got.block_kind !== want.block_kind ||
            got.body_byte !== want.body_byte || got.error_code !== want.error_code ||
            got.final_res !== want.final_res)
          report_mismatch("field", want, got);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // ---------------- stimulus helpers ----------------

  task automatic add_text(input logic [7:0] c);
    text_q = {text_q, c};
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == CH_HASH || c == CH_OPEN || c == CH_CLOSE || c == CH_SPACE ||
           c == CH_TAB || c == CH_LF || c == CH_NUL);
    return c;
  endfunction

  // Whitespace run or a comment
  task automatic push_filler();
    if ($urandom_range(1) == 0) begin
      repeat ($urandom_range(1, 3))
        case ($urandom_range(3))
          0: add_text(CH_SPACE);
          1: add_text(CH_TAB);
          2: add_text(CH_LF);
          default: add_text(CH_NUL);
        endcase
    end else begin
      add_text(CH_HASH);
      repeat ($urandom_range(0, 5)) begin
        if ($urandom_range(3) == 0)
          add_text($urandom_range(1) ? CH_OPEN : CH_CLOSE);
        else
          add_text(plain_byte());
      end
      add_text(CH_HASH);
    end
  endtask

  task automatic push_known_name(input blk_t b, input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0) add_text(CH_SPACE);
      add_text(known_char(b, i));
    end
  endtask

  task automatic push_name();
    int unsigned r;
    blk_t b;
    r = $urandom_range(99);
    b = blk_t'($urandom_range(2));
    if (r < 70) begin
      push_known_name(b, known_len(b));
    end else if (r < 80) begin
      // overlong: a valid name with a tail
      push_known_name(b, known_len(b));
      repeat ($urandom_range(1, 10)) add_text(plain_byte());
    end else if (r < 88) begin
      // empty name
    end else if (r < 94) begin
      push_known_name(b, $urandom_range(1, known_len(b) - 1));
    end else begin
      repeat ($urandom_range(1, 9)) add_text(plain_byte());
    end
  endtask

  // One text stream: mostly well-formed blocks with random bodies, some noise.
  task automatic send_random_stream();
    int unsigned open_cnt;
    int unsigned r;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 24)) add_text(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(2) == 0) push_filler();
        push_name();
        add_text(CH_OPEN);
        open_cnt = 0;
        repeat ($urandom_range(0, 10)) begin
          r = $urandom_range(99);
          if (r < 15) begin
            add_text(CH_OPEN);
            open_cnt++;
          end else if (r < 30 && open_cnt != 0) begin
            add_text(CH_CLOSE);
            open_cnt--;
          end else if (r < 38) begin
            push_filler();
          end else begin
            add_text(plain_byte());
          end
        end
        repeat (open_cnt) add_text(CH_CLOSE);
        // now and then leave the block open
        if ($urandom_range(19) != 0) add_text(CH_CLOSE);
      end
      if ($urandom_range(19) == 0) add_text(CH_CLOSE);
      if ($urandom_range(3) == 0) push_filler();
    end
    send_text_q();
  endtask

  // ---------------- tests ----------------

  // All three block types, nesting, body byte extremes, clean end
  task automatic test_block_types();
    send_text("Plane{a", 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h01, 1'b0);
    send_text("}Point3d{{}}Cube{}", 1'b0);
    send_beat(CH_NUL, 1'b1);
  endtask

  // Filtering: comments hide braces, whitespace inside names; final '}' yields two tokens
  task automatic test_filtering();
    send_text("# } { #\tCu be\n{#}#q}", 1'b1);
  endtask

  task automatic test_error_cases();
    send_text("}x", 1'b1);           // stray close, then halted final byte
    send_text("Point3dXY{", 1'b1);   // overlong name, error on the final byte
    wait_drained();
    send_text("{ ", 1'b1);           // empty name
    send_text("Cube{x", 1'b1);       // open body at end of stream
    send_text("Cu", 1'b1);           // pending name at end of stream
    wait_drained();
    send_text(" ", 1'b1);            // empty stream, end ok only
    send_text("}", 1'b1);            // stray close on the final byte
    send_text("#", 1'b1);            // final byte inside a comment
    wait_drained();
  endtask

  // Depth saturation while the receiver holds off, so the block backs up
  task automatic test_too_deep();
    tx_quiet = 1'b1;
    holdoff_req = 400;
    send_text("Cube{", 1'b0);
    repeat (MAX_DEPTH_DEF) send_beat(CH_OPEN, 1'b0);
    send_beat(CH_CLOSE, 1'b0);
    send_beat(CH_OPEN, 1'b0);
    send_beat(CH_OPEN, 1'b0);        // one past the limit
    send_beat(CH_OPEN, 1'b0);        // halted, no token
    send_beat("z", 1'b1);
    tx_quiet = 1'b0;
    wait_drained();
  endtask

  // Random streams until the whole run reaches about 950 beats
  task automatic test_random_streams();
    int unsigned start;
    start = beats_sent;
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    while (beats_sent - start < 200) send_random_stream();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    while (beats_sent < 950) send_random_stream();
  endtask

  initial begin
    reset_parser();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_block_types();
    test_filtering();
    test_error_cases();
    test_too_deep();
    test_random_streams();
    s_tvalid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && token_q.size() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
